// ===== design/bpam_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the page allocator.
package bpam_pkg;

  localparam int MAX_PAGES  = 4096;
  localparam int MAX_RUN    = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int WORD_BITS  = 32;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int MAP_WORDS  = MAX_PAGES / WORD_BITS;
  localparam int MAP_AW     = $clog2(MAP_WORDS);
  localparam int IDX_W      = $clog2(MAX_PAGES);
  localparam int NUM_W      = IDX_W + 1;
  localparam int DIR_SLOTS  = 1024;
  localparam int DIR_WORDS  = DIR_SLOTS / WORD_BITS;
  localparam int DIR_AW     = $clog2(DIR_WORDS);
  localparam int SLOT_W     = $clog2(DIR_SLOTS);
  localparam int COUNT_W    = 6;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VIRT_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_PAGES = 2'd2;

  localparam logic [31:0]      VIRT_BASE_RST  = 32'hC010_0000;
  localparam logic [31:0]      PHYS_BASE_RST  = 32'h0020_0000;
  localparam logic [NUM_W-1:0] POOL_PAGES_RST = NUM_W'(3840);

  localparam logic [31:0] ENTRY_FLAGS = 32'h0000_0007;
  localparam logic [9:0]  PTE_WINDOW  = 10'h3FF;
  localparam logic [19:0] PDE_WINDOW  = 20'hFFFFF;

  typedef enum logic [1:0] {
    ST_MAPPED  = 2'd0,
    ST_NO_VIRT = 2'd1,
    ST_NO_PHYS = 2'd2
  } status_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic v_rd;
    logic v_step;
    logic m_rd;
    logic m_wr;
    logic pg_init;
    logic p_rd;
    logic p_take;
    logic p_next;
    logic d_rd;
    logic d_wr;
    logic tbl_set;
    logic emit_ok;
    logic emit_vfail;
    logic emit_pfail;
    logic pg_next;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic bad_cnt;
    logic v_end;
    logic v_found;
    logic v_wordend;
    logic m_last;
    logic p_out;
    logic p_hit;
    logic d_present;
    logic tbl;
    logic pg_last;
  } stat_t;

endpackage

// ===== design/bpam_ram.sv =====
// Generic single-port-write, registered-read RAM.
module bpam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bpam_ctrl.sv =====
// Controller state machine sequencing scans, marking and result transfers.
module bpam_ctrl import bpam_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_CLR  = 12'b0000_0000_0001,
    S_IDLE = 12'b0000_0000_0010,
    S_VRD  = 12'b0000_0000_0100,
    S_VBIT = 12'b0000_0000_1000,
    S_MRD  = 12'b0000_0001_0000,
    S_MWR  = 12'b0000_0010_0000,
    S_PGI  = 12'b0000_0100_0000,
    S_PRD  = 12'b0000_1000_0000,
    S_PCHK = 12'b0001_0000_0000,
    S_DRD  = 12'b0010_0000_0000,
    S_DCHK = 12'b0100_0000_0000,
    S_EMIT = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_VRD;
        end
      end
      S_VRD: begin
        if (st.bad_cnt || st.v_end) begin
          cmd.emit_vfail = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.v_rd  = 1'b1;
          state_nxt = S_VBIT;
        end
      end
      S_VBIT: begin
        if (st.v_end) begin
          cmd.emit_vfail = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.v_step = 1'b1;
          if (st.v_found) state_nxt = S_MRD;
          else if (st.v_wordend) state_nxt = S_VRD;
        end
      end
      S_MRD: begin
        cmd.m_rd  = 1'b1;
        state_nxt = S_MWR;
      end
      S_MWR: begin
        cmd.m_wr  = 1'b1;
        state_nxt = st.m_last ? S_PGI : S_MRD;
      end
      S_PGI: begin
        cmd.pg_init = 1'b1;
        state_nxt   = S_PRD;
      end
      S_PRD: begin
        if (st.p_out) begin
          cmd.emit_pfail = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.p_rd  = 1'b1;
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        if (st.p_hit) begin
          cmd.p_take = 1'b1;
          if (st.tbl) begin
            cmd.d_wr  = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_DRD;
          end
        end else begin
          cmd.p_next = 1'b1;
          state_nxt  = S_PRD;
        end
      end
      S_DRD: begin
        cmd.d_rd  = 1'b1;
        state_nxt = S_DCHK;
      end
      S_DCHK: begin
        if (st.d_present) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.tbl_set = 1'b1;
          state_nxt   = S_PRD;
        end
      end
      S_EMIT: begin
        cmd.emit_ok = 1'b1;
        cmd.pg_next = 1'b1;
        state_nxt   = st.pg_last ? S_IDLE : S_PGI;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  assign busy = (state_r != S_IDLE);

`ifndef NO_ASSERTIONS
  a_take_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.p_take |-> st.p_hit) else $error("physical take without a free bit");
  a_dir_write_only_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.d_wr |-> st.tbl) else $error("directory write without a table page");
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> state_r == S_CLR) else $error("reset did not start the clearing pass");
`endif

endmodule

// ===== design/bpam_dp.sv =====
// Datapath: bitmap memories, scan counters, configuration and result registers.
module bpam_dp import bpam_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output stat_t                st,
  input  logic [COUNT_W-1:0]   in_page_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [31:0]          out_virt_addr,
  output logic [31:0]          out_phys_addr,
  output logic [31:0]          out_pte_addr,
  output logic [31:0]          out_pte_value,
  output logic                 out_pde_write,
  output logic [31:0]          out_pde_addr,
  output logic [31:0]          out_pde_value,
  output logic                 out_last
);

  logic [31:0]        virt_base_r, phys_base_r;
  logic [NUM_W-1:0]   pool_r;
  logic [MAP_AW-1:0]  clr_idx_r;
  logic [COUNT_W-1:0] cnt_r, run_r, pg_r;
  logic [NUM_W-1:0]   vidx_r;
  logic [IDX_W-1:0]   start_r, midx_r;
  logic [MAP_AW:0]    pw_r;
  logic               tbl_r;
  logic [31:0]        va_r, pa_r, table_r;

  logic               out_valid_r, out_pde_write_r, out_last_r;
  logic [1:0]         out_status_r;
  logic [31:0]        out_va_r, out_pa_r, out_pta_r, out_ptv_r, out_pda_r, out_pdv_r;

  logic [WORD_BITS-1:0] v_rdata, p_rdata, d_rdata;
  logic [WORD_BITS-1:0] v_wdata, p_wdata, d_wdata, m_mask, elig, p_free;
  logic [MAP_AW-1:0]    v_raddr, v_waddr, p_waddr;
  logic [DIR_AW-1:0]    d_waddr;
  logic [NUM_W-1:0]     n_pages, p_base_idx, p_rem;
  logic [IDX_W-1:0]     run_end, found_start, page_idx, p_idx;
  logic [BIT_W-1:0]     m_hi, lz;
  logic [SLOT_W-1:0]    slot;
  logic [31:0]          p_addr, va_calc;

  assign n_pages = (pool_r > NUM_W'(MAX_PAGES)) ? NUM_W'(MAX_PAGES) : pool_r;
  assign slot    = va_r[31:32-SLOT_W];

  // Virtual run scan and marking.
  assign run_end     = start_r + IDX_W'(cnt_r) - IDX_W'(1);
  assign found_start = vidx_r[IDX_W-1:0] - IDX_W'(cnt_r) + IDX_W'(1);
  assign m_hi        = (run_end[IDX_W-1:BIT_W] == midx_r[IDX_W-1:BIT_W]) ?
                       run_end[BIT_W-1:0] : BIT_W'(WORD_BITS - 1);
  assign m_mask      = ({WORD_BITS{1'b1}} << midx_r[BIT_W-1:0]) &
                       ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - m_hi));
  assign v_raddr     = cmd.v_rd ? vidx_r[IDX_W-1:BIT_W] : midx_r[IDX_W-1:BIT_W];
  assign v_waddr     = cmd.clr ? clr_idx_r : midx_r[IDX_W-1:BIT_W];
  assign v_wdata     = cmd.clr ? '0 : (v_rdata | m_mask);

  // Physical lowest-free search, one word per read.
  assign p_base_idx = {pw_r, {BIT_W{1'b0}}};
  assign p_rem      = n_pages - p_base_idx;
  assign elig       = (p_rem >= NUM_W'(WORD_BITS)) ? {WORD_BITS{1'b1}} :
                      ((WORD_BITS'(1) << p_rem[BIT_W-1:0]) - WORD_BITS'(1));
  assign p_free     = ~p_rdata & elig;

  always_comb begin
    lz = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (p_free[i]) lz = BIT_W'(i);
    end
  end

  assign p_idx   = {pw_r[MAP_AW-1:0], lz};
  assign p_addr  = phys_base_r + (32'(p_idx) << PAGE_SHIFT);
  assign p_waddr = cmd.clr ? clr_idx_r : pw_r[MAP_AW-1:0];
  assign p_wdata = cmd.clr ? '0 : (p_rdata | (WORD_BITS'(1) << lz));

  assign d_waddr = cmd.clr ? clr_idx_r[DIR_AW-1:0] : slot[SLOT_W-1:BIT_W];
  assign d_wdata = cmd.clr ? '0 : (d_rdata | (WORD_BITS'(1) << slot[BIT_W-1:0]));

  assign page_idx = start_r + IDX_W'(pg_r);
  assign va_calc  = virt_base_r + (32'(page_idx) << PAGE_SHIFT);

  bpam_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_virt_map (
    .clk(clk), .we(cmd.clr | cmd.m_wr), .waddr(v_waddr), .wdata(v_wdata),
    .re(cmd.v_rd | cmd.m_rd), .raddr(v_raddr), .rdata(v_rdata)
  );

  bpam_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_phys_map (
    .clk(clk), .we(cmd.clr | cmd.p_take), .waddr(p_waddr), .wdata(p_wdata),
    .re(cmd.p_rd), .raddr(pw_r[MAP_AW-1:0]), .rdata(p_rdata)
  );

  bpam_ram #(.WIDTH(WORD_BITS), .DEPTH(DIR_WORDS)) u_dir_map (
    .clk(clk), .we(cmd.clr | cmd.d_wr), .waddr(d_waddr), .wdata(d_wdata),
    .re(cmd.d_rd), .raddr(slot[SLOT_W-1:BIT_W]), .rdata(d_rdata)
  );

  always_comb begin
    st           = '0;
    st.clr_done  = (clr_idx_r == MAP_AW'(MAP_WORDS - 1));
    st.bad_cnt   = (cnt_r == '0) || (cnt_r > COUNT_W'(MAX_RUN));
    st.v_end     = (vidx_r == n_pages);
    st.v_found   = !v_rdata[vidx_r[BIT_W-1:0]] && (run_r + COUNT_W'(1) == cnt_r);
    st.v_wordend = (vidx_r[BIT_W-1:0] == BIT_W'(WORD_BITS - 1));
    st.m_last    = (run_end[IDX_W-1:BIT_W] == midx_r[IDX_W-1:BIT_W]);
    st.p_out     = (p_base_idx >= n_pages);
    st.p_hit     = |p_free;
    st.d_present = d_rdata[slot[BIT_W-1:0]];
    st.tbl       = tbl_r;
    st.pg_last   = (pg_r + COUNT_W'(1) == cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      virt_base_r <= VIRT_BASE_RST;
      phys_base_r <= PHYS_BASE_RST;
      pool_r      <= POOL_PAGES_RST;
      clr_idx_r   <= '0;
      pw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VIRT_BASE:  virt_base_r <= cfg_wdata;
          CFG_PHYS_BASE:  phys_base_r <= cfg_wdata;
          CFG_POOL_PAGES: begin
            // A larger pool can free up words the search has already passed.
            pool_r <= cfg_wdata[NUM_W-1:0];
            pw_r   <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.clr) begin
        clr_idx_r <= clr_idx_r + MAP_AW'(1);
        pw_r      <= '0;
      end
      if (cmd.p_next) pw_r <= pw_r + (MAP_AW+1)'(1);
      out_valid_r <= cmd.emit_ok | cmd.emit_vfail | cmd.emit_pfail;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt_r  <= in_page_count;
      vidx_r <= '0;
      run_r  <= '0;
      pg_r   <= '0;
    end
    if (cmd.v_step) begin
      vidx_r <= vidx_r + NUM_W'(1);
      run_r  <= v_rdata[vidx_r[BIT_W-1:0]] ? '0 : run_r + COUNT_W'(1);
      if (st.v_found) begin
        start_r <= found_start;
        midx_r  <= found_start;
      end
    end
    if (cmd.m_wr) midx_r <= {midx_r[IDX_W-1:BIT_W] + MAP_AW'(1), {BIT_W{1'b0}}};
    if (cmd.pg_init) begin
      va_r  <= va_calc;
      tbl_r <= 1'b0;
    end
    if (cmd.tbl_set) tbl_r <= 1'b1;
    if (cmd.p_take) begin
      if (tbl_r) table_r <= p_addr;
      else pa_r <= p_addr;
    end
    if (cmd.pg_next) pg_r <= pg_r + COUNT_W'(1);

    if (cmd.emit_ok) begin
      out_status_r    <= ST_MAPPED;
      out_va_r        <= va_r;
      out_pa_r        <= pa_r;
      out_pta_r       <= {PTE_WINDOW, va_r[31:22], va_r[21:12], 2'b00};
      out_ptv_r       <= pa_r | ENTRY_FLAGS;
      out_pde_write_r <= tbl_r;
      out_pda_r       <= tbl_r ? {PDE_WINDOW, slot, 2'b00} : 32'd0;
      out_pdv_r       <= tbl_r ? (table_r | ENTRY_FLAGS) : 32'd0;
      out_last_r      <= st.pg_last;
    end else if (cmd.emit_vfail || cmd.emit_pfail) begin
      out_status_r    <= cmd.emit_vfail ? ST_NO_VIRT : ST_NO_PHYS;
      out_va_r        <= cmd.emit_vfail ? 32'd0 : va_r;
      out_pa_r        <= '0;
      out_pta_r       <= '0;
      out_ptv_r       <= '0;
      out_pde_write_r <= 1'b0;
      out_pda_r       <= '0;
      out_pdv_r       <= '0;
      out_last_r      <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_virt_addr = out_va_r;
  assign out_phys_addr = out_pa_r;
  assign out_pte_addr  = out_pta_r;
  assign out_pte_value = out_ptv_r;
  assign out_pde_write = out_pde_write_r;
  assign out_pde_addr  = out_pda_r;
  assign out_pde_value = out_pdv_r;
  assign out_last      = out_last_r;

`ifndef NO_ASSERTIONS
  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_MAPPED) |-> out_last_r)
    else $error("failure transfer not marked last");
  a_pde_only_mapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pde_write_r |-> out_status_r == ST_MAPPED)
    else $error("directory write on a failure transfer");
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.emit_ok, cmd.emit_vfail, cmd.emit_pfail}) <= 1)
    else $error("two result kinds in one cycle");
`endif

endmodule

// ===== design/bitmap_page_allocator_mapper.sv =====
// Top level of the bitmap page allocator and mapper.
//
// A request (in_page_count) is taken at a clock edge with start high and busy
// low. The block finds the first run of that many free virtual pages, marks
// it used, then takes the lowest free pool page for each page (plus a table
// page when the directory slot is empty) and sends one transfer per page on
// the out_ ports, each shown for exactly one cycle with out_valid high.
// A failure ends the request with one transfer whose out_last is high.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) are taken at once; the
// user must make them only while busy is low; the block does not enforce it.
// The receiver cannot stall the block. The virtual scan reads each 32-bit
// bitmap word and tests its bits one by one up to the run end; marking reads
// and writes back each word touched; each page takes a pool search, one word
// per read, a directory read, and a second search when a table page is taken.
// The search resumes at the last word that had a free page; a pool_pages write
// sends it back to word 0. Each transfer is registered onto the out_ ports.
// One request is in work at a time; the bitmap memory ports set the pace.
// After reset a clearing pass zeroes the bitmaps with busy high.
module bitmap_page_allocator_mapper import bpam_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [COUNT_W-1:0]   in_page_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [31:0]          out_virt_addr,
  output logic [31:0]          out_phys_addr,
  output logic [31:0]          out_pte_addr,
  output logic [31:0]          out_pte_value,
  output logic                 out_pde_write,
  output logic [31:0]          out_pde_addr,
  output logic [31:0]          out_pde_value,
  output logic                 out_last
);

  cmd_t  cmd;
  stat_t st;

  bpam_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .st(st), .cmd(cmd)
  );

  bpam_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_page_count(in_page_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_status(out_status),
    .out_virt_addr(out_virt_addr), .out_phys_addr(out_phys_addr),
    .out_pte_addr(out_pte_addr), .out_pte_value(out_pte_value),
    .out_pde_write(out_pde_write), .out_pde_addr(out_pde_addr),
    .out_pde_value(out_pde_value), .out_last(out_last)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the bitmap page allocator and mapper.
module tb_top;
  import bpam_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [31:0] pte_addr;
    logic [31:0] pte_value;
    logic        pde_write;
    logic [31:0] pde_addr;
    logic [31:0] pde_value;
    logic        last;
  } map_res_t;

  typedef struct {
    logic [COUNT_W-1:0] count;
    bit                 typed;
    map_res_t           res;
  } req_row_t;

  typedef struct {
    logic [31:0] vbase;
    logic [31:0] pbase;
    logic [31:0] pool;
    int          n_req;
    int          idle_pct;
  } phase_t;

  localparam int LIMIT = 10_000_000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [COUNT_W-1:0]   in_page_count = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_VIRT_BASE;
  logic [31:0]          cfg_wdata = '0;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic [31:0]          out_virt_addr, out_phys_addr, out_pte_addr, out_pte_value;
  logic                 out_pde_write;
  logic [31:0]          out_pde_addr, out_pde_value;
  logic                 out_last;

  bitmap_page_allocator_mapper DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state.
  logic [31:0] heap_base, pool_base;
  logic [12:0] frame_limit;
  bit          heap_used [MAX_PAGES];
  bit          frame_used [MAX_PAGES];
  bit          slot_present [DIR_SLOTS];

  map_res_t expected_maps[$];
  map_res_t typed_res;
  bit       typed_pending = 0;
  int       accepted = 0;
  int       errors = 0;
  int       cycles = 0;

  function automatic int free_run(bit is_heap, int len);
    int n, run;
    n = (frame_limit > MAX_PAGES) ? MAX_PAGES : frame_limit;
    run = 0;
    for (int i = 0; i < n; i++) begin
      if (is_heap ? heap_used[i] : frame_used[i]) run = 0;
      else begin
        run++;
        if (run == len) return i + 1 - len;
      end
    end
    return -1;
  endfunction

  task automatic map_request(input logic [COUNT_W-1:0] count);
    int first, frame, tbl;
    logic [31:0] va;
    logic [9:0] slot;
    map_res_t r;
    first = (count == 0 || count > MAX_RUN) ? -1 : free_run(1, count);
    if (first < 0) begin
      r = '0;
      r.status = ST_NO_VIRT;
      r.last = 1'b1;
      expected_maps.push_back(r);
      return;
    end
    for (int i = 0; i < count; i++) heap_used[first + i] = 1;
    for (int i = 0; i < count; i++) begin
      r = '0;
      va = heap_base + 32'(first + i) * 32'd4096;
      slot = va[31:22];
      frame = free_run(0, 1);
      if (frame >= 0) begin
        frame_used[frame] = 1;
        if (!slot_present[slot]) begin
          tbl = free_run(0, 1);
          if (tbl >= 0) begin
            frame_used[tbl] = 1;
            slot_present[slot] = 1;
            r.pde_write = 1'b1;
            r.pde_addr = 32'hFFFFF000 + {20'd0, slot, 2'd0};
            r.pde_value = (pool_base + 32'(tbl) * 32'd4096) | ENTRY_FLAGS;
          end
        end else tbl = 0;
      end
      if (frame < 0 || tbl < 0) begin
        r = '0;
        r.status = ST_NO_PHYS;
        r.virt_addr = va;
        r.last = 1'b1;
        expected_maps.push_back(r);
        return;
      end
      r.status = ST_MAPPED;
      r.virt_addr = va;
      r.phys_addr = pool_base + 32'(frame) * 32'd4096;
      r.pte_addr = 32'hFFC00000 + {10'd0, va[31:22], 12'd0} + {20'd0, va[21:12], 2'd0};
      r.pte_value = r.phys_addr | ENTRY_FLAGS;
      r.last = (i + 1 == count);
      expected_maps.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    map_res_t got, want;
    int n0;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_n && out_valid) begin
      got = '{out_status, out_virt_addr, out_phys_addr, out_pte_addr, out_pte_value,
              out_pde_write, out_pde_addr, out_pde_value, out_last};
      if (expected_maps.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer %h", $time, got);
      end else begin
        want = expected_maps.pop_front();
        if (got.status !== want.status || got.virt_addr !== want.virt_addr ||
            got.phys_addr !== want.phys_addr || got.pte_addr !== want.pte_addr ||
            got.pte_value !== want.pte_value || got.pde_write !== want.pde_write ||
            got.pde_addr !== want.pde_addr || got.pde_value !== want.pde_value ||
            got.last !== want.last) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
        end
      end
    end
    if (rst_n && start && !busy) begin
      n0 = expected_maps.size();
      map_request(in_page_count);
      if (typed_pending) begin
        // The predictor state is kept up to date; its output is replaced.
        while (expected_maps.size() > n0) void'(expected_maps.pop_back());
        expected_maps.push_back(typed_res);
        typed_pending = 0;
      end
      accepted++;
    end
  end

  task automatic send_request(input logic [COUNT_W-1:0] count, input int idle_pct);
    int n0;
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    n0 = accepted;
    start = 1'b1;
    in_page_count = count;
    do @(negedge clk); while (accepted == n0);
    start = 1'b0;
    in_page_count = 6'($urandom);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_VIRT_BASE: heap_base = val;
      CFG_PHYS_BASE: pool_base = val;
      CFG_POOL_PAGES: frame_limit = val[12:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (expected_maps.size() != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 80) return COUNT_W'($urandom_range(1, MAX_RUN));
    if (r < 90) return COUNT_W'($urandom_range(0, 63));
    return COUNT_W'(1);
  endfunction

  req_row_t rows[$];
  phase_t   phases[$];
  map_res_t fail_virt;

  initial begin
    heap_base = VIRT_BASE_RST;
    pool_base = PHYS_BASE_RST;
    frame_limit = POOL_PAGES_RST;
    fail_virt = '0;
    fail_virt.status = ST_NO_VIRT;
    fail_virt.last = 1'b1;
    rows.push_back('{6'd1, 1, '{ST_MAPPED, 32'hC0100000, 32'h00200000, 32'hFFF00400,
                              32'h00200007, 1'b1, 32'hFFFFFC00, 32'h00201007, 1'b1}});
    rows.push_back('{6'd0, 1, fail_virt});
    rows.push_back('{6'd33, 1, fail_virt});
    rows.push_back('{6'd63, 1, fail_virt});
    foreach (rows[i]) ;
    rows.push_back('{6'd32, 0, '0});
    rows.push_back('{6'd2, 0, '0});
    rows.push_back('{6'd31, 0, '0});
    rows.push_back('{6'd16, 0, '0});
    rows.push_back('{6'd8, 0, '0});
    rows.push_back('{6'd4, 0, '0});
    rows.push_back('{6'd1, 0, '0});

    phases.push_back('{32'h00000000, 32'h00000000, 32'd8191, 50, 0});
    phases.push_back('{32'hFFFFF000, 32'hFFFFF000, 32'd4096, 45, 57});
    phases.push_back('{32'h003FE000, 32'h12345000, 32'd1, 6, 17});
    phases.push_back('{32'h80000000, 32'h00001000, 32'd0, 4, 0});
    phases.push_back('{32'h7FC03000, 32'h00400000, 32'd4096, 95, 57});

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    wait_idle();
    foreach (rows[i]) begin
      typed_pending = rows[i].typed;
      typed_res = rows[i].res;
      send_request(rows[i].count, (i % 2) ? 57 : 0);
    end
    foreach (phases[p]) begin
      wait_idle();
      write_reg(CFG_VIRT_BASE, phases[p].vbase);
      write_reg(CFG_PHYS_BASE, phases[p].pbase);
      write_reg(CFG_POOL_PAGES, phases[p].pool);
      for (int k = 0; k < phases[p].n_req; k++)
        send_request(pick_count(), (k % 20 < 5) ? 0 : phases[p].idle_pct);
    end
    wait_idle();
    repeat (50) @(negedge clk);
    if (errors == 0 && expected_maps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== bitmap_page_allocator_mapper.f =====
design/bpam_pkg.sv
design/bpam_ram.sv
design/bpam_ctrl.sv
design/bpam_dp.sv
design/bitmap_page_allocator_mapper.sv
sim/tb_top.sv
